>>> rtl/tfes_pkg.sv
// Shared types, constants and helpers of the timed fuse event sequencer.
`timescale 1ns / 1ps
package tfes_pkg;
	localparam int EVENT_DEPTH         = 256;
	localparam int BOARD_COUNT         = 16;
	localparam int LIT_DEPTH           = 16;
	localparam int MAX_LIGHTS_PER_TICK = 32;
	localparam int MAX_OUT             = 64;
	localparam int MAX_EXT             = MAX_OUT - MAX_LIGHTS_PER_TICK;
	localparam int EV_AW  = $clog2(EVENT_DEPTH);
	localparam int CNT_W  = $clog2(EVENT_DEPTH + 1);
	localparam int LIT_AW = (LIT_DEPTH > 1) ? $clog2(LIT_DEPTH) : 1;
	localparam int LIT_CW = $clog2(LIT_DEPTH + 1);
	localparam int STEP_W = $clog2(MAX_OUT + 1);
	localparam logic [4:0] REG_BASE = 5'h14;

	localparam logic [2:0] MODE_TICK  = 3'd0;
	localparam logic [2:0] MODE_LOAD  = 3'd1;
	localparam logic [2:0] MODE_PLAY  = 3'd2;
	localparam logic [2:0] MODE_PAUSE = 3'd3;
	localparam logic [2:0] MODE_STOP  = 3'd4;
	localparam logic [2:0] MODE_JUMP  = 3'd5;

	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_LIGHT  = 2'd1;
	localparam logic [1:0] KIND_EXT    = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_PLAYING  = 2'd1;
	localparam logic [1:0] ST_PAUSED   = 2'd2;
	localparam logic [1:0] ST_BEYOND   = 2'd3;

	localparam logic CFG_EVENT_COUNT = 1'b0;
	localparam logic CFG_FUSE_ON     = 1'b1;

	typedef struct packed {
		logic [31:0] ev_time;
		logic [3:0]  dev;
		logic [3:0]  fuse;
	} ev_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [3:0] board;
		logic [4:0] reg_address;
		logic [7:0] bit_mask;
		logic [7:0] fired_slot;
		logic [1:0] status;
	} res_t;

	function automatic logic [7:0] chan_mask(input logic [1:0] ch);
		logic [7:0] m;
		unique case (ch)
			2'd0: m = 8'b00000011;
			2'd1: m = 8'b00001100;
			2'd2: m = 8'b00110000;
			default: m = 8'b11000000;
		endcase
		return m;
	endfunction
endpackage

>>> rtl/tfes_event_ram.sv
// Event table memory: one write port, one registered read port.
`timescale 1ns / 1ps
module tfes_event_ram (
	input  logic                  clk,
	input  logic                  we,
	input  logic [tfes_pkg::EV_AW-1:0] waddr,
	input  tfes_pkg::ev_t         wdata,
	input  logic [tfes_pkg::EV_AW-1:0] raddr,
	output tfes_pkg::ev_t         rdata
);
	import tfes_pkg::*;

	ev_t mem [EVENT_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/timed_fuse_event_sequencer.sv
// Top level of the timed fuse event sequencer.
`timescale 1ns / 1ps
// Channel  Handshake              Payload
// in       in_valid / in_ready    mode, event_index, event_time, device_index,
//                                 fuse_number, jump_target
// out      out_valid / out_ready  kind, board, reg_address, bit_mask, fired_slot,
//                                 status, playing, paused, last
// cfg      cfg_we                 cfg_index, cfg_data
//
// One transaction at a time. A load completes without leaving idle; play/pause/stop
// pass through S_FIN. A tick first counts due extinguishes and, when playing, walks
// the due entries once without output to learn whether playback ends, so every result
// carries the final flags; then it emits the extinguishes and the table entries taken,
// paced by the one event RAM read port (registered read). Jump scans the table entry
// by entry. Reset clears clocks, flags and the lit FIFO; the event RAM is not cleared.
// A result waits in a hold register so its last flag is known; a stalled output stops
// the sequencer only when both hold and output registers are full.
module timed_fuse_event_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  mode,
	input  logic [7:0]  event_index,
	input  logic [31:0] event_time,
	input  logic [3:0]  device_index,
	input  logic [3:0]  fuse_number,
	input  logic [31:0] jump_target,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [3:0]  board,
	output logic [4:0]  reg_address,
	output logic [7:0]  bit_mask,
	output logic [7:0]  fired_slot,
	output logic [1:0]  status,
	output logic        playing,
	output logic        paused,
	output logic        last,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	import tfes_pkg::*;

	typedef enum logic [14:0] {
		S_IDLE   = 15'b000000000000001,
		S_XCHK   = 15'b000000000000010,
		S_XEMIT  = 15'b000000000000100,
		S_LSTART = 15'b000000000001000,
		S_LCHK   = 15'b000000000010000,
		S_LEVAL  = 15'b000000000100000,
		S_JLAST  = 15'b000000001000000,
		S_JLASTV = 15'b000000010000000,
		S_JRD    = 15'b000000100000000,
		S_JEV    = 15'b000001000000000,
		S_FIN    = 15'b000010000000000,
		S_XCNT   = 15'b000100000000000,
		S_DSTART = 15'b001000000000000,
		S_DCHK   = 15'b010000000000000,
		S_DEVAL  = 15'b100000000000000
	} state_t;

	state_t state_q;

	// configuration
	logic [CNT_W-1:0] event_count_q;
	logic [15:0]      fuse_on_q;
	logic [CNT_W-1:0] cnt;

	// sequencer state
	logic [CNT_W-1:0] next_slot_q;
	logic [31:0]      play_q, wall_q, jt_q, total_q;
	logic             run_q, pause_q;
	logic [CNT_W-1:0] scan_q;
	logic [STEP_W-1:0] step_q;

	// dry walk: does this tick end playback
	logic [CNT_W-1:0]  dslot_q;
	logic [LIT_CW-1:0] dlit_q;
	logic              halt_pend_q;
	logic [31:0]       play_inc;

	// lit FIFO, read from the head (the counting pass also looks past it)
	logic [31:0]       lf_expire [LIT_DEPTH];
	logic [EV_AW-1:0]  lf_slot   [LIT_DEPTH];
	logic [LIT_AW-1:0] lit_head_q;
	logic [LIT_CW-1:0] lit_count_q;
	logic [LIT_AW-1:0] lit_tail;
	logic [LIT_AW-1:0] x_idx;
	logic [31:0]       age;

	// result hold and output registers
	res_t hold_q, out_q, emit_res;
	logic hold_v_q, out_v_q, out_run_q, out_pause_q, out_last_q;
	logic out_free, gen_ok, emit, fin_push, halt_now;

	ev_t              rd;
	ev_t              wr;
	logic [EV_AW-1:0] rd_addr;
	logic [EV_AW-1:0] rd_addr_prev_q;
	logic             accept, board_ok, exp_due, at_end;

	assign cnt = (event_count_q > CNT_W'(EVENT_DEPTH)) ? CNT_W'(EVENT_DEPTH) : event_count_q;
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_v_q || out_ready;
	assign gen_ok   = !hold_v_q || out_free;
	assign lit_tail = LIT_AW'(lit_head_q + LIT_AW'(lit_count_q));
	assign board_ok = ({1'b0, rd.dev} < 5'(BOARD_COUNT));
	// counting pass looks past the head, emit pass at the head
	assign x_idx    = (state_q == S_XCNT) ? LIT_AW'(lit_head_q + LIT_AW'(step_q)) : lit_head_q;
	assign age      = wall_q - lf_expire[x_idx];
	assign exp_due  = !age[31];
	assign at_end   = (next_slot_q + CNT_W'(1)) == cnt;
	assign play_inc = (play_q != 32'hFFFF_FFFF) ? play_q + 32'd1 : play_q;
	assign wr = '{ev_time: event_time, dev: device_index, fuse: fuse_number};

	tfes_event_ram u_ram (
		.clk   (clk),
		.we    (accept && mode == MODE_LOAD && int'(event_index) < EVENT_DEPTH),
		.waddr (EV_AW'(event_index)),
		.wdata (wr),
		.raddr (rd_addr),
		.rdata (rd)
	);

	// RAM address for the entry the next state looks at
	always_comb begin
		rd_addr = EV_AW'(next_slot_q);
		unique case (state_q)
			S_XCHK, S_XEMIT: rd_addr = lf_slot[lit_head_q];
			S_DCHK, S_DEVAL: rd_addr = EV_AW'(dslot_q);
			S_JLAST: rd_addr = EV_AW'(cnt - CNT_W'(1));
			S_JRD:   rd_addr = EV_AW'(scan_q);
			default: rd_addr = EV_AW'(next_slot_q);
		endcase
	end

	// result generation
	always_comb begin
		emit     = 1'b0;
		emit_res = '0;
		halt_now = 1'b0;
		fin_push = (state_q == S_FIN) && hold_v_q && out_free;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (mode)
						MODE_PLAY: begin
							emit = 1'b1;
							emit_res.status = run_q ? ST_PLAYING : ST_OK;
						end
						MODE_PAUSE: begin
							emit = 1'b1;
							emit_res.status = run_q ? ST_OK : ST_PAUSED;
						end
						MODE_STOP: emit = 1'b1;
						MODE_JUMP: begin
							if (cnt == '0) begin
								emit = 1'b1;
								emit_res.status = (jump_target != 32'd0) ? ST_BEYOND : ST_OK;
							end
						end
						default: emit = 1'b0;
					endcase
				end
			end
			S_XEMIT: begin
				emit = gen_ok;
				emit_res.kind = KIND_EXT;
			end
			S_LEVAL: begin
				if (rd.ev_time <= play_q && board_ok && lit_count_q < LIT_CW'(LIT_DEPTH)) begin
					emit = gen_ok;
					emit_res.kind = KIND_LIGHT;
				end
				if (rd.ev_time <= play_q && at_end
						&& (!board_ok || (lit_count_q < LIT_CW'(LIT_DEPTH) && gen_ok))) begin
					halt_now = 1'b1;
				end
			end
			S_JRD, S_JEV: begin
				if ((state_q == S_JRD && scan_q == cnt)
						|| (state_q == S_JEV && rd.ev_time >= jt_q)) begin
					emit = 1'b1;
					emit_res.status = (jt_q > total_q) ? ST_BEYOND : ST_OK;
				end
			end
			default: emit = 1'b0;
		endcase
		if (emit_res.kind != KIND_STATUS) begin
			emit_res.board       = rd.dev;
			emit_res.reg_address = REG_BASE + 5'(rd.fuse[3:2]);
			emit_res.bit_mask    = chan_mask(rd.fuse[1:0]);
			emit_res.fired_slot  = 8'(rd_addr_prev_q);
		end
	end

	// slot that the current RAM data belongs to
	always_ff @(posedge clk) begin
		rd_addr_prev_q <= rd_addr;
	end

	// hold and output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (emit) begin
				hold_v_q <= 1'b1;
			end else if (fin_push) begin
				hold_v_q <= 1'b0;
			end
			if ((emit && hold_v_q) || fin_push) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// a tick that ends playback reports stopped flags on all its results
	always_ff @(posedge clk) begin
		if (emit) begin
			hold_q <= emit_res;
		end
		if (emit && hold_v_q) begin
			out_q       <= hold_q;
			out_last_q  <= 1'b0;
			out_run_q   <= halt_pend_q ? 1'b0 : run_q;
			out_pause_q <= halt_pend_q ? 1'b0 : pause_q;
		end else if (fin_push) begin
			out_q       <= hold_q;
			out_last_q  <= 1'b1;
			out_run_q   <= run_q;
			out_pause_q <= pause_q;
		end
	end

	// lit FIFO payload
	always_ff @(posedge clk) begin
		if (state_q == S_LEVAL && emit) begin
			lf_expire[lit_tail] <= wall_q + 32'(fuse_on_q);
			lf_slot[lit_tail]   <= EV_AW'(next_slot_q);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			event_count_q <= '0;
			fuse_on_q     <= '0;
			next_slot_q   <= '0;
			play_q        <= '0;
			wall_q        <= '0;
			run_q         <= 1'b0;
			pause_q       <= 1'b0;
			lit_head_q    <= '0;
			lit_count_q   <= '0;
			scan_q        <= '0;
			step_q        <= '0;
			jt_q          <= '0;
			total_q       <= '0;
			dslot_q       <= '0;
			dlit_q        <= '0;
			halt_pend_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_EVENT_COUNT: event_count_q <= CNT_W'(cfg_data);
					default:         fuse_on_q     <= cfg_data;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						halt_pend_q <= 1'b0;
						unique case (mode)
							MODE_TICK: begin
								wall_q  <= wall_q + 32'd1;
								step_q  <= '0;
								state_q <= S_XCNT;
							end
							MODE_PLAY: begin
								if (!run_q) begin
									run_q   <= 1'b1;
									pause_q <= 1'b0;
								end
								state_q <= S_FIN;
							end
							MODE_PAUSE: begin
								if (run_q) begin
									run_q   <= 1'b0;
									pause_q <= 1'b1;
								end
								state_q <= S_FIN;
							end
							MODE_STOP: begin
								run_q       <= 1'b0;
								pause_q     <= 1'b0;
								play_q      <= '0;
								next_slot_q <= '0;
								state_q     <= S_FIN;
							end
							MODE_JUMP: begin
								play_q <= jump_target;
								jt_q   <= jump_target;
								scan_q <= '0;
								if (cnt == '0) begin
									next_slot_q <= '0;
									state_q     <= S_FIN;
								end else begin
									state_q <= S_JLAST;
								end
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				// count the extinguishes due this tick
				S_XCNT: begin
					if (step_q < STEP_W'(lit_count_q) && exp_due) begin
						step_q <= step_q + STEP_W'(1);
					end else begin
						state_q <= S_DSTART;
					end
				end
				S_DSTART: begin
					dslot_q <= next_slot_q;
					dlit_q  <= lit_count_q - LIT_CW'(step_q);
					step_q  <= '0;
					state_q <= run_q ? S_DCHK : S_XCHK;
				end
				// dry walk of the lights, same decisions as S_LEVAL
				S_DCHK: begin
					if (step_q < STEP_W'(MAX_LIGHTS_PER_TICK) && dslot_q < cnt) begin
						state_q <= S_DEVAL;
					end else begin
						step_q  <= '0;
						state_q <= S_XCHK;
					end
				end
				S_DEVAL: begin
					if (rd.ev_time > play_inc || (board_ok && dlit_q >= LIT_CW'(LIT_DEPTH))) begin
						step_q  <= '0;
						state_q <= S_XCHK;
					end else begin
						if (board_ok) begin
							dlit_q <= dlit_q + LIT_CW'(1);
						end
						if ((dslot_q + CNT_W'(1)) == cnt) begin
							halt_pend_q <= 1'b1;
							step_q      <= '0;
							state_q     <= S_XCHK;
						end else begin
							dslot_q <= dslot_q + CNT_W'(1);
							step_q  <= step_q + STEP_W'(1);
							state_q <= S_DCHK;
						end
					end
				end
				S_XCHK: begin
					if (lit_count_q != '0 && step_q < STEP_W'(MAX_EXT) && exp_due) begin
						state_q <= S_XEMIT;
					end else begin
						state_q <= S_LSTART;
					end
				end
				S_XEMIT: begin
					if (emit) begin
						lit_head_q  <= LIT_AW'(lit_head_q + LIT_AW'(1));
						lit_count_q <= lit_count_q - LIT_CW'(1);
						step_q      <= step_q + STEP_W'(1);
						state_q     <= S_XCHK;
					end
				end
				S_LSTART: begin
					step_q <= '0;
					if (!run_q) begin
						state_q <= S_FIN;
					end else begin
						play_q  <= play_inc;
						state_q <= S_LCHK;
					end
				end
				S_LCHK: begin
					if (run_q && step_q < STEP_W'(MAX_LIGHTS_PER_TICK) && next_slot_q < cnt) begin
						state_q <= S_LEVAL;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_LEVAL: begin
					if (rd.ev_time > play_q) begin
						state_q <= S_FIN;
					end else if (board_ok && lit_count_q >= LIT_CW'(LIT_DEPTH)) begin
						state_q <= S_FIN;
					end else if (!board_ok || emit) begin
						if (emit) begin
							lit_count_q <= lit_count_q + LIT_CW'(1);
						end
						step_q <= step_q + STEP_W'(1);
						if (halt_now) begin
							run_q       <= 1'b0;
							pause_q     <= 1'b0;
							play_q      <= '0;
							next_slot_q <= '0;
						end else begin
							next_slot_q <= next_slot_q + CNT_W'(1);
						end
						state_q <= S_LCHK;
					end
				end
				S_JLAST: state_q <= S_JLASTV;
				S_JLASTV: begin
					// last event time plus on-time, saturated
					if (({1'b0, rd.ev_time} + 33'(fuse_on_q)) > 33'h0_FFFF_FFFF) begin
						total_q <= 32'hFFFF_FFFF;
					end else begin
						total_q <= rd.ev_time + 32'(fuse_on_q);
					end
					state_q <= S_JRD;
				end
				S_JRD: begin
					if (scan_q == cnt) begin
						next_slot_q <= cnt;
						state_q     <= S_FIN;
					end else begin
						state_q <= S_JEV;
					end
				end
				S_JEV: begin
					if (rd.ev_time >= jt_q) begin
						next_slot_q <= scan_q;
						state_q     <= S_FIN;
					end else begin
						scan_q  <= scan_q + CNT_W'(1);
						state_q <= S_JRD;
					end
				end
				S_FIN: begin
					if (!hold_v_q || out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid   = out_v_q;
	assign kind        = out_q.kind;
	assign board       = out_q.board;
	assign reg_address = out_q.reg_address;
	assign bit_mask    = out_q.bit_mask;
	assign fired_slot  = out_q.fired_slot;
	assign status      = out_q.status;
	assign playing     = out_run_q;
	assign paused      = out_pause_q;
	assign last        = out_last_q;
endmodule

>>> bench/fuse_action_checker.sv
// Checker: predicts the fuse actions and status of each transaction and compares them.
`timescale 1ns / 1ps
module fuse_action_checker
	import tfes_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [2:0]  mode,
	input  logic [7:0]  event_index,
	input  logic [31:0] event_time,
	input  logic [3:0]  device_index,
	input  logic [3:0]  fuse_number,
	input  logic [31:0] jump_target,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  kind,
	input  logic [3:0]  board,
	input  logic [4:0]  reg_address,
	input  logic [7:0]  bit_mask,
	input  logic [7:0]  fired_slot,
	input  logic [1:0]  status,
	input  logic        playing,
	input  logic        paused,
	input  logic        last,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	output int          pending,
	output int          errors
);
	typedef struct packed {
		res_t r;
		logic playing;
		logic paused;
		logic last;
	} action_t;

	action_t     due_actions[$];
	action_t     batch[$];
	logic [8:0]  n_events;
	logic [15:0] on_ms;
	logic [31:0] tbl_time[EVENT_DEPTH];
	logic [3:0]  tbl_dev[EVENT_DEPTH];
	logic [3:0]  tbl_fuse[EVENT_DEPTH];
	int          nxt;
	logic [31:0] play_ms;
	logic [31:0] wall_ms;
	logic        run, hold;
	logic [31:0] lit_expire[LIT_DEPTH];
	logic [7:0]  lit_slot[LIT_DEPTH];
	int          lit_head, lit_n;

	task automatic add_action(input logic [1:0] k, input logic [7:0] s, input logic [1:0] st);
		action_t a;
		a = '0;
		a.r.kind = k;
		a.r.status = st;
		if (k != KIND_STATUS) begin
			a.r.board = tbl_dev[s];
			a.r.reg_address = REG_BASE + 5'(tbl_fuse[s][3:2]);
			a.r.bit_mask = chan_mask(tbl_fuse[s][1:0]);
			a.r.fired_slot = s;
		end
		batch.push_back(a);
	endtask

	task automatic stop_playback();
		run = 0;
		hold = 0;
		play_ms = '0;
		nxt = 0;
	endtask

	task automatic forecast_item();
		int          cnt, ext, w, i;
		logic [7:0]  s;
		logic [31:0] age;
		logic [32:0] total;
		cnt = (n_events > EVENT_DEPTH) ? EVENT_DEPTH : int'(n_events);
		batch = {};
		case (mode)
			MODE_TICK: begin
				wall_ms++;
				ext = 0;
				while (lit_n > 0 && ext < MAX_EXT) begin
					age = wall_ms - lit_expire[lit_head];
					if (age[31]) break;
					add_action(KIND_EXT, lit_slot[lit_head], ST_OK);
					lit_head = (lit_head + 1) % LIT_DEPTH;
					lit_n--;
					ext++;
				end
				if (run) begin
					if (play_ms != '1) play_ms++;
					for (int taken = 0; taken < MAX_LIGHTS_PER_TICK; taken++) begin
						if (!run || nxt >= cnt) break;
						s = nxt[7:0];
						if (tbl_time[s] > play_ms) break;
						if (int'(tbl_dev[s]) < BOARD_COUNT) begin
							if (lit_n >= LIT_DEPTH) break;
							w = (lit_head + lit_n) % LIT_DEPTH;
							lit_expire[w] = wall_ms + 32'(on_ms);
							lit_slot[w] = s;
							lit_n++;
							add_action(KIND_LIGHT, s, ST_OK);
						end
						nxt++;
						if (nxt == cnt) stop_playback();
					end
				end
			end
			MODE_LOAD: begin
				tbl_time[event_index] = event_time;
				tbl_dev[event_index] = device_index;
				tbl_fuse[event_index] = fuse_number;
			end
			MODE_PLAY: begin
				if (run) add_action(KIND_STATUS, 0, ST_PLAYING);
				else begin
					run = 1;
					hold = 0;
					add_action(KIND_STATUS, 0, ST_OK);
				end
			end
			MODE_PAUSE: begin
				if (!run) add_action(KIND_STATUS, 0, ST_PAUSED);
				else begin
					run = 0;
					hold = 1;
					add_action(KIND_STATUS, 0, ST_OK);
				end
			end
			MODE_STOP: begin
				stop_playback();
				add_action(KIND_STATUS, 0, ST_OK);
			end
			MODE_JUMP: begin
				total = '0;
				if (cnt > 0) begin
					total = {1'b0, tbl_time[cnt-1]} + 33'(on_ms);
					if (total[32]) total = {1'b0, 32'hFFFF_FFFF};
				end
				play_ms = jump_target;
				for (i = 0; i < cnt; i++)
					if (tbl_time[i] >= jump_target) break;
				nxt = i;
				add_action(KIND_STATUS, 0, ({1'b0, jump_target} > total) ? ST_BEYOND : ST_OK);
			end
			default: ;
		endcase
		foreach (batch[k]) begin
			batch[k].playing = run;
			batch[k].paused = hold;
			batch[k].last = (k == batch.size() - 1);
			due_actions.push_back(batch[k]);
		end
	endtask

	task automatic compare(input string name, input logic [31:0] exp_v, input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			errors++;
		end
	endtask

	initial begin
		errors = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		action_t e;
		if (!arst_n) begin
			due_actions = {};
			pending = 0;
			n_events = '0;
			on_ms = '0;
			nxt = 0;
			play_ms = '0;
			wall_ms = '0;
			run = 0;
			hold = 0;
			lit_head = 0;
			lit_n = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_EVENT_COUNT) n_events = cfg_data[8:0];
				else on_ms = cfg_data;
			end
			if (in_valid && in_ready) forecast_item();
			if (out_valid && out_ready) begin
				if (due_actions.size() == 0) begin
					$error("result with nothing expected: kind %0d slot %0d", kind, fired_slot);
					errors++;
				end else begin
					e = due_actions.pop_front();
					compare("kind", 32'(e.r.kind), 32'(kind));
					compare("board", 32'(e.r.board), 32'(board));
					compare("reg_address", 32'(e.r.reg_address), 32'(reg_address));
					compare("bit_mask", 32'(e.r.bit_mask), 32'(bit_mask));
					compare("fired_slot", 32'(e.r.fired_slot), 32'(fired_slot));
					compare("status", 32'(e.r.status), 32'(status));
					compare("playing", 32'(e.playing), 32'(playing));
					compare("paused", 32'(e.paused), 32'(paused));
					compare("last", 32'(e.last), 32'(last));
				end
			end
			pending = due_actions.size();
		end
	end
endmodule

>>> bench/tb.sv
// Testbench top: stimulus, configuration phases, watchdog and verdict for the sequencer.
`timescale 1ns / 1ps
module tb;
	import tfes_pkg::*;

	// settle time after the last expected result: covers a full jump scan
	localparam int DRAIN_CYCLES = 600;
	// cycles with no transaction on either channel before giving up
	localparam int STALL_LIMIT = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  mode = MODE_TICK;
	logic [7:0]  event_index = '0;
	logic [31:0] event_time = '0;
	logic [3:0]  device_index = '0;
	logic [3:0]  fuse_number = '0;
	logic [31:0] jump_target = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [3:0]  board;
	logic [4:0]  reg_address;
	logic [7:0]  bit_mask;
	logic [7:0]  fired_slot;
	logic [1:0]  status;
	logic        playing, paused, last;
	logic        cfg_we = 1'b0;
	logic        cfg_index = CFG_EVENT_COUNT;
	logic [15:0] cfg_data = '0;

	int pending, errors;
	int snd_idle_pct = 36;
	int rcv_idle_pct = 48;
	int quiet_cycles = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	timed_fuse_event_sequencer dut (.*);

	fuse_action_checker chk (.*);

	// Receiver back-pressure, redrawn every cycle.
	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= rcv_idle_pct);

	// Watchdog: a hung handshake on either side ends the run.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// One transaction on the input channel; valid holds until accepted.
	task automatic send(input logic [2:0] m, input logic [7:0] idx, input logic [31:0] t,
			input logic [3:0] dev, input logic [3:0] fz, input logic [31:0] tgt);
		@(negedge clk);
		while ($urandom_range(99) < snd_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		mode = m;
		event_index = idx;
		event_time = t;
		device_index = dev;
		fuse_number = fz;
		jump_target = tgt;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	// Control transaction with junk in the unused payload fields.
	task automatic command(input logic [2:0] m, input logic [31:0] tgt);
		send(m, 8'($urandom), $urandom, 4'($urandom), 4'($urandom), tgt);
	endtask

	// Drain: nothing outstanding, then let any silent tick work finish.
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_registers(input int n_ev, input int on_t);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = CFG_EVENT_COUNT;
		cfg_data = 16'(n_ev);
		@(negedge clk);
		cfg_index = CFG_FUSE_ON;
		cfg_data = 16'(on_t);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Non-decreasing schedule in slots 0..n-1; must precede any play or jump.
	task automatic load_schedule(input int n, input int max_step);
		logic [31:0] t;
		t = $urandom_range(3);
		for (int i = 0; i < n; i++) begin
			send(MODE_LOAD, 8'(i), t, 4'($urandom), 4'($urandom), $urandom);
			t += $urandom_range(max_step);
		end
	endtask

	// Mostly ticks so playback gets somewhere; play and jump only when the
	// live part of the table is fully written.
	task automatic random_items(input int n, input bit can_play, input int t_span);
		int          pick;
		logic [31:0] tgt;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			tgt = ($urandom_range(4) == 0) ? $urandom : $urandom_range(t_span);
			if (pick < 55) command(MODE_TICK, $urandom);
			else if (pick < 64)
				send(MODE_LOAD, 8'($urandom),
					($urandom_range(3) == 0) ? $urandom : $urandom_range(t_span),
					4'($urandom), 4'($urandom), $urandom);
			else if (pick < 76) command(can_play ? MODE_PLAY : MODE_TICK, $urandom);
			else if (pick < 82) command(MODE_PAUSE, $urandom);
			else if (pick < 86) command(MODE_STOP, $urandom);
			else if (pick < 97) command(can_play ? MODE_JUMP : MODE_STOP, tgt);
			else command(3'($urandom_range(6, 7)), $urandom);
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		set_registers(0, 0);

		// Empty table: status paths, unused modes, table extremes.
		command(MODE_TICK, '0);
		command(MODE_PAUSE, '0);          // paused while stopped
		command(MODE_PLAY, '0);
		command(MODE_PLAY, '0);           // already playing
		command(MODE_TICK, '0);           // nothing to fire
		command(MODE_JUMP, 32'd5);        // beyond a zero-length show
		command(MODE_PAUSE, '0);
		command(MODE_PLAY, '0);
		command(MODE_STOP, '0);
		command(3'd6, '1);
		command(3'd7, '1);
		send(MODE_LOAD, 8'd0, 32'd0, 4'hF, 4'hF, '1);
		send(MODE_LOAD, 8'd1, 32'd1, 4'h0, 4'h0, '0);
		send(MODE_LOAD, 8'd2, 32'd1, 4'h5, 4'h6, '0);
		send(MODE_LOAD, 8'd3, 32'hFFFF_FFFF, 4'hA, 4'h9, '0);
		send(MODE_LOAD, 8'd255, 32'h8000_0000, 4'h3, 4'hC, '0);
		settle();

		// Four events, zero on-time: time-0 fire, same-ms pair, saturated clock.
		set_registers(4, 0);
		command(MODE_PLAY, '0);
		command(MODE_TICK, '0);
		command(MODE_TICK, '0);
		command(MODE_TICK, '0);
		command(MODE_JUMP, 32'hFFFF_FFFF);
		command(MODE_TICK, '0);           // last event ends playback
		command(MODE_TICK, '0);
		settle();

		set_registers(12, 5);
		load_schedule(12, 6);
		random_items(35, 1'b1, 80);
		settle();

		snd_idle_pct = 48;
		rcv_idle_pct = 36;
		// Dense burst: more due events than one tick may take.
		set_registers(40, 0);
		load_schedule(40, 0);
		random_items(35, 1'b1, 20);
		settle();

		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		// Long on-time fills the lit queue; later events wait for room.
		set_registers(20, 65535);
		load_schedule(20, 2);
		random_items(35, 1'b1, 50);
		settle();

		// Full table count; no play or jump, so unwritten slots stay unread.
		set_registers(256, 1);
		command(MODE_STOP, '0);
		random_items(12, 1'b0, 100);
		settle();

		if (errors == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
